FILE: rtl/fdss_pkg.sv
`default_nettype none

package fdss_pkg;

  localparam logic [1:0] OpDecimal = 2'd0;
  localparam logic [1:0] OpHex     = 2'd1;
  localparam logic [1:0] OpChar    = 2'd2;

  localparam logic [7:0] CodeDash  = 8'd16;
  localparam logic [7:0] CodeBlank = 8'd17;
  localparam int unsigned NumMapLen = 18;
  localparam logic [7:0] AsciiFirst = 8'd32;
  localparam logic [7:0] AsciiLast  = 8'd127;

  localparam logic [7:0] SegBlank = 8'hFF;
  localparam logic [7:0] DotMask  = 8'h7F;

  localparam logic [7:0] NumMap [NumMapLen] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90,
    8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E, 8'hBF, 8'hFF
  };

  // Active-high glyphs for ASCII 32 to 127.
  localparam logic [7:0] AsciiMap [96] = '{
    8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'hD2, 8'h46, 8'h20,
    8'h29, 8'h0B, 8'h21, 8'h70, 8'h10, 8'h40, 8'h80, 8'h52,
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
    8'h7F, 8'h6F, 8'h09, 8'h0D, 8'h61, 8'h48, 8'h43, 8'hD3,
    8'h5F, 8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h76, 8'h30, 8'h1E, 8'h75, 8'h38, 8'h15, 8'h37, 8'h3F,
    8'h73, 8'h6B, 8'h33, 8'h6D, 8'h78, 8'h3E, 8'h3E, 8'h2A,
    8'h76, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h23, 8'h08,
    8'h02, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h71, 8'h6F,
    8'h74, 8'h10, 8'h0C, 8'h75, 8'h30, 8'h14, 8'h54, 8'h5C,
    8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h1C, 8'h14,
    8'h76, 8'h6E, 8'h5B, 8'h46, 8'h30, 8'h70, 8'h01, 8'h00
  };

  // Reciprocal of ten for 16-bit operands: x / 10 == (x * 52429) >> 19.
  localparam logic [31:0] RecipTen = 32'd52429;
  localparam int unsigned RecipShift = 19;

  typedef struct packed {
    logic [7:0] code;
    logic [1:0] pos;
    logic       dot;
    logic       last;
  } beat_t;

endpackage

`default_nettype wire

FILE: rtl/fdss_glyph.sv
`default_nettype none

module fdss_glyph (
  input  wire logic [7:0] code_i,
  input  wire logic       dot_i,
  output logic      [7:0] segments_o
);

  logic [6:0] ascii_idx;
  logic [7:0] seg;

  assign ascii_idx = code_i[6:0] - fdss_pkg::AsciiFirst[6:0];

  always_comb begin
    if (code_i < 8'(fdss_pkg::NumMapLen)) begin
      seg = fdss_pkg::NumMap[code_i[4:0]];
    end else if (code_i >= fdss_pkg::AsciiFirst && code_i <= fdss_pkg::AsciiLast) begin
      seg = ~fdss_pkg::AsciiMap[ascii_idx];
    end else begin
      seg = fdss_pkg::SegBlank;
    end
  end

  assign segments_o = dot_i ? (seg & fdss_pkg::DotMask) : seg;

endmodule

`default_nettype wire

FILE: rtl/fdss_seq.sv
`default_nettype none

module fdss_seq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire logic [1:0]        operation_i,
  input  wire logic [15:0]       value_i,
  input  wire logic [1:0]        digit_position_i,
  input  wire logic [7:0]        char_code_i,
  input  wire logic              dot_i,
  input  wire logic              advance_i,
  output logic                   busy_o,
  output fdss_pkg::beat_t        beat_o
);

  logic        busy_q, busy_d;
  logic [1:0]  op_q, op_d;
  logic [15:0] work_q, work_d;
  logic        neg_q, neg_d;
  logic        more_q, more_d;
  logic        dash_q, dash_d;
  logic [1:0]  pos_q, pos_d;
  logic        dot_q, dot_d;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] rem;
  logic        digit_ok;
  fdss_pkg::beat_t beat;

  assign prod     = 32'(work_q) * fdss_pkg::RecipTen;
  assign quot     = 16'(prod[31:fdss_pkg::RecipShift]);
  assign rem      = work_q - {quot[12:0], 3'b000} - {quot[14:0], 1'b0};
  assign digit_ok = more_q && (!neg_q || pos_q != 2'd0);

  always_comb begin
    beat.pos  = pos_q;
    beat.dot  = 1'b0;
    beat.last = (pos_q == 2'd0);
    unique case (op_q)
      fdss_pkg::OpDecimal: begin
        if (digit_ok) begin
          beat.code = {4'b0000, rem[3:0]};
        end else if (neg_q && !dash_q) begin
          beat.code = fdss_pkg::CodeDash;
        end else begin
          beat.code = fdss_pkg::CodeBlank;
        end
      end
      fdss_pkg::OpHex: begin
        beat.code = {4'b0000, work_q[3:0]};
      end
      fdss_pkg::OpChar: begin
        beat.code = work_q[7:0];
        beat.dot  = dot_q;
        beat.last = 1'b1;
      end
      default: begin
        beat.code = fdss_pkg::CodeBlank;
        beat.last = 1'b1;
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    work_d = work_q;
    neg_d  = neg_q;
    more_d = more_q;
    dash_d = dash_q;
    pos_d  = pos_q;
    dot_d  = dot_q;
    if (load_i) begin
      busy_d = (operation_i == fdss_pkg::OpDecimal) || (operation_i == fdss_pkg::OpHex)
               || (operation_i == fdss_pkg::OpChar);
      op_d   = operation_i;
      neg_d  = (operation_i == fdss_pkg::OpDecimal) && value_i[15];
      more_d = 1'b1;
      dash_d = 1'b0;
      dot_d  = dot_i;
      pos_d  = (operation_i == fdss_pkg::OpChar) ? digit_position_i : 2'd3;
      if (operation_i == fdss_pkg::OpChar) begin
        work_d = {8'h00, char_code_i};
      end else if ((operation_i == fdss_pkg::OpDecimal) && value_i[15]) begin
        work_d = 16'(~value_i + 16'd1);
      end else begin
        work_d = value_i;
      end
    end else if (advance_i) begin
      busy_d = !beat.last;
      pos_d  = pos_q - 2'd1;
      if (op_q == fdss_pkg::OpHex) begin
        work_d = {4'h0, work_q[15:4]};
      end else if (op_q == fdss_pkg::OpDecimal) begin
        if (digit_ok) begin
          work_d = quot;
          more_d = (quot != 16'd0);
        end else if (neg_q) begin
          dash_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    work_q <= work_d;
    neg_q  <= neg_d;
    more_q <= more_d;
    dash_q <= dash_d;
    pos_q  <= pos_d;
    dot_q  <= dot_d;
  end

  assign busy_o = busy_q;
  assign beat_o = beat;

endmodule

`default_nettype wire

FILE: rtl/four_digit_seven_segment_formatter_top.sv
`default_nettype none

// Channel   Direction  tdata (low bit up)                                 tuser      tlast
// s_axis    in         value[15:0] digit_position[17:16] char_code[25:18]  operation  -
//                      dot[26], zero pad to 32 bits
// m_axis    out        segments[7:0] digit_select[11:8], zero pad to 16     -          last
//
// A decimal or hex request gives four writes, one per cycle unless the output stalls, and
// occupies the digit sequencer until the last of them; a character request gives one write
// and an unused operation code is consumed with no output.
// The next request is taken in the cycle the sequencer hands its final write to the
// output register, so requests follow each other without a gap.
// A stalled output holds the output register and the sequencer; reset is asynchronous
// and clears only the busy and valid flags.

module four_digit_seven_segment_formatter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // value, digit_position, char_code, dot
  input  wire logic [1:0]  s_axis_tuser,  // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,  // segments, digit_select
  output logic             m_axis_tlast
);

  logic            busy;
  logic            advance;
  logic            load;
  fdss_pkg::beat_t beat;
  logic [7:0]      seg;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      seg_q;
  logic [3:0]      sel_q;
  logic            last_q;

  assign advance       = busy && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !busy || (advance && beat.last);
  assign load          = s_axis_tvalid && s_axis_tready;

  fdss_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (load),
    .operation_i      (s_axis_tuser),
    .value_i          (s_axis_tdata[15:0]),
    .digit_position_i (s_axis_tdata[17:16]),
    .char_code_i      (s_axis_tdata[25:18]),
    .dot_i            (s_axis_tdata[26]),
    .advance_i        (advance),
    .busy_o           (busy),
    .beat_o           (beat)
  );

  fdss_glyph u_glyph (
    .code_i     (beat.code),
    .dot_i      (beat.dot),
    .segments_o (seg)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      seg_q  <= seg;
      sel_q  <= 4'b0001 << beat.pos;
      last_q <= beat.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, sel_q, seg_q};
  assign m_axis_tlast  = last_q;

endmodule

`default_nettype wire

FILE: verif/tb_four_digit_seven_segment_formatter_top.sv
module tb_four_digit_seven_segment_formatter_top;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned RandCmds = 205;
  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned DrainCycles = 16;

  typedef struct packed {
    logic [7:0] seg;
    logic [3:0] sel;
    logic       last;
  } digit_write_t;

  // One display request; when typed is set, segs holds the segment bytes in write order.
  typedef struct packed {
    logic [1:0]       op;
    logic [15:0]      value;
    logic [1:0]       pos;
    logic [7:0]       code;
    logic             dot;
    logic             typed;
    logic [2:0]       n_writes;
    logic [0:3][7:0]  segs;
  } display_cmd_t;

  localparam int unsigned DirRows = 25;
  localparam display_cmd_t DirTab [DirRows] = '{
    '{fdss_pkg::OpDecimal, 16'h0000, 2'd0, 8'd0, 1'b0, 1'b1, 3'd4, '{8'hC0, 8'hFF, 8'hFF, 8'hFF}},
    '{fdss_pkg::OpDecimal, 16'h7FFF, 2'd1, 8'd5, 1'b1, 1'b1, 3'd4, '{8'hF8, 8'h82, 8'hF8, 8'hA4}},
    '{fdss_pkg::OpDecimal, 16'h8000, 2'd3, 8'd255, 1'b1, 1'b1, 3'd4,
      '{8'h80, 8'h82, 8'hF8, 8'hBF}},
    '{fdss_pkg::OpDecimal, 16'hFFFF, 2'd2, 8'd17, 1'b0, 1'b1, 3'd4,
      '{8'hF9, 8'hBF, 8'hFF, 8'hFF}},
    '{fdss_pkg::OpDecimal, 16'h0001, 2'd0, 8'd0, 1'b0, 1'b1, 3'd4, '{8'hF9, 8'hFF, 8'hFF, 8'hFF}},
    '{fdss_pkg::OpDecimal, 16'd12345, 2'd0, 8'd0, 1'b0, 1'b0, 3'd0, '0},
    '{fdss_pkg::OpDecimal, 16'hFC19, 2'd0, 8'd0, 1'b0, 1'b0, 3'd0, '0},
    '{fdss_pkg::OpDecimal, 16'hFC18, 2'd0, 8'd0, 1'b0, 1'b0, 3'd0, '0},
    '{fdss_pkg::OpDecimal, 16'd10, 2'd0, 8'd0, 1'b0, 1'b0, 3'd0, '0},
    '{fdss_pkg::OpHex, 16'h0000, 2'd3, 8'd0, 1'b1, 1'b1, 3'd4, '{8'hC0, 8'hC0, 8'hC0, 8'hC0}},
    '{fdss_pkg::OpHex, 16'hFFFF, 2'd0, 8'd255, 1'b1, 1'b1, 3'd4, '{8'h8E, 8'h8E, 8'h8E, 8'h8E}},
    '{fdss_pkg::OpHex, 16'h1234, 2'd0, 8'd0, 1'b0, 1'b0, 3'd0, '0},
    '{fdss_pkg::OpHex, 16'hA5C3, 2'd0, 8'd0, 1'b0, 1'b0, 3'd0, '0},
    '{fdss_pkg::OpChar, 16'hFFFF, 2'd0, 8'd0, 1'b0, 1'b1, 3'd1, '{8'hC0, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd3, 8'd15, 1'b1, 1'b1, 3'd1, '{8'h0E, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd1, 8'd16, 1'b0, 1'b1, 3'd1, '{8'hBF, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd2, 8'd17, 1'b1, 1'b1, 3'd1, '{8'h7F, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd0, 8'd18, 1'b0, 1'b1, 3'd1, '{8'hFF, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd1, 8'd32, 1'b0, 1'b1, 3'd1, '{8'hFF, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd2, 8'd46, 1'b0, 1'b1, 3'd1, '{8'h7F, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd0, 8'd127, 1'b1, 1'b1, 3'd1, '{8'h7F, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd3, 8'd128, 1'b0, 1'b1, 3'd1, '{8'hFF, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd0, 8'd255, 1'b1, 1'b1, 3'd1, '{8'h7F, 8'h00, 8'h00, 8'h00}},
    '{fdss_pkg::OpChar, 16'h0000, 2'd2, 8'd65, 1'b0, 1'b0, 3'd0, '0},
    '{OpUnused, 16'hFFFF, 2'd3, 8'd255, 1'b1, 1'b1, 3'd0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  digit_write_t pending_writes [$];
  int unsigned  error_count = 0;
  int unsigned  accepted_cmds = 0;
  int unsigned  cycle_count = 0;

  four_digit_seven_segment_formatter_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [7:0] glyph_of(logic [7:0] code, logic dot);
    logic [7:0] seg;
    seg = fdss_pkg::SegBlank;
    if (code < fdss_pkg::NumMapLen) begin
      seg = fdss_pkg::NumMap[code];
    end else if (code >= fdss_pkg::AsciiFirst && code <= fdss_pkg::AsciiLast) begin
      seg = ~fdss_pkg::AsciiMap[code - fdss_pkg::AsciiFirst];
    end
    if (dot) begin
      seg = seg & fdss_pkg::DotMask;
    end
    return seg;
  endfunction

  task automatic predict_writes(display_cmd_t c);
    logic [7:0]  digit [4];
    logic [16:0] mag;
    int          p;
    int          stop;
    logic        neg;
    if (c.op == fdss_pkg::OpChar) begin
      pending_writes.push_back(digit_write_t'{glyph_of(c.code, c.dot), 4'b0001 << c.pos, 1'b1});
    end else if (c.op == fdss_pkg::OpDecimal || c.op == fdss_pkg::OpHex) begin
      if (c.op == fdss_pkg::OpDecimal) begin
        neg = c.value[15];
        mag = neg ? 17'h10000 - {1'b0, c.value} : {1'b0, c.value};
        stop = neg ? 1 : 0;
        for (p = 0; p < 4; p++) begin
          digit[p] = fdss_pkg::CodeBlank;
        end
        p = 3;
        do begin
          digit[p] = 8'(mag % 17'd10);
          mag = mag / 17'd10;
          p--;
        end while (mag != 0 && p >= stop);
        if (neg && p >= 0) begin
          digit[p] = fdss_pkg::CodeDash;
        end
      end else begin
        for (p = 0; p < 4; p++) begin
          digit[p] = {4'h0, c.value[(3 - p) * 4 +: 4]};
        end
      end
      for (p = 3; p >= 0; p--) begin
        pending_writes.push_back(digit_write_t'{glyph_of(digit[p], 1'b0), 4'(1 << p), p == 0});
      end
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic issue_cmd(display_cmd_t c, int gap);
    int k;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, c.dot, c.code, c.pos, c.value};
    s_axis_tuser  <= c.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    accepted_cmds++;
    if (c.typed) begin
      for (k = 0; k < c.n_writes; k++) begin
        if (c.op == fdss_pkg::OpChar) begin
          pending_writes.push_back(digit_write_t'{c.segs[k], 4'b0001 << c.pos, 1'b1});
        end else begin
          pending_writes.push_back(digit_write_t'{c.segs[k], 4'(1 << (3 - k)), k == 3});
        end
      end
    end else begin
      predict_writes(c);
    end
    @(negedge clk_i);
  endtask

  function automatic display_cmd_t random_cmd();
    display_cmd_t c;
    int unsigned  pick;
    c = '0;
    c.value = 16'($urandom);
    c.pos   = 2'($urandom);
    c.code  = 8'($urandom);
    c.dot   = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      c.op = fdss_pkg::OpDecimal;
      case ($urandom_range(0, 4))
        0: c.value = 16'($urandom_range(0, 99));
        1: c.value = 16'(-$urandom_range(1, 1100));
        2: c.value = 16'h8000 + 16'($urandom_range(0, 3));
        3: c.value = 16'h7FFF - 16'($urandom_range(0, 3));
        default: ;
      endcase
    end else if (pick < 60) begin
      c.op = fdss_pkg::OpHex;
    end else if (pick < 95) begin
      c.op = fdss_pkg::OpChar;
      case ($urandom_range(0, 5))
        0, 1: c.code = 8'($urandom_range(0, 17));
        2, 3: c.code = 8'($urandom_range(32, 127));
        4: c.code = 8'($urandom_range(18, 31));
        default: c.code = 8'($urandom_range(128, 255));
      endcase
    end else begin
      c.op = OpUnused;
    end
    return c;
  endfunction

  initial begin
    int unsigned  i;
    int unsigned  sent;
    int           gap;
    logic         send_burst;
    display_cmd_t c;
    send_burst = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    for (i = 0; i < DirRows; i++) begin
      issue_cmd(DirTab[i], (i % 5 == 0) ? 0 : $urandom_range(0, 15));
    end
    sent = 0;
    i = 0;
    while (sent < RandCmds) begin
      if (i % 16 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
      end
      c = random_cmd();
      gap = send_burst ? 0 : $urandom_range(0, 15);
      if (accepted_cmds >= 110 && accepted_cmds < 150) begin
        gap = 0;
      end
      issue_cmd(c, gap);
      sent++;
      i++;
    end
    s_axis_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int unsigned  n;
    int           w;
    logic         held_off;
    logic         stall_burst;
    digit_write_t want;
    held_off = 1'b0;
    stall_burst = 1'b0;
    n = 0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (n % 16 == 0) begin
        stall_burst = ($urandom_range(0, 3) == 0);
      end
      w = stall_burst ? 0 : $urandom_range(0, 15);
      if (!held_off && accepted_cmds >= 120) begin
        held_off = 1'b1;
        w = HoldOffCycles;
      end
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      n++;
      if (pending_writes.size() == 0) begin
        $error("unexpected digit write: segments %h digit_select %h last %b",
               m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast);
        error_count++;
      end else begin
        want = pending_writes.pop_front();
        if (m_axis_tdata[7:0] !== want.seg) begin
          $error("segments: expected %h, actual %h", want.seg, m_axis_tdata[7:0]);
          error_count++;
        end
        if (m_axis_tdata[11:8] !== want.sel) begin
          $error("digit_select: expected %h, actual %h", want.sel, m_axis_tdata[11:8]);
          error_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, actual %b", want.last, m_axis_tlast);
          error_count++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fdss_pkg.sv
rtl/fdss_glyph.sv
rtl/fdss_seq.sv
rtl/four_digit_seven_segment_formatter_top.sv
verif/tb_four_digit_seven_segment_formatter_top.sv
